// File: src/xsr_pkg.sv
package xsr_pkg;

  // operation codes of the kind field
  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_OR  = 4'd1,
    OP_XOR = 4'd2,
    OP_SHL = 4'd3,
    OP_SHR = 4'd4,
    OP_SAR = 4'd5,
    OP_ROL = 4'd6,
    OP_ROR = 4'd7,
    OP_RCL = 4'd8,
    OP_RCR = 4'd9
  } kind_t;

  localparam logic [15:0] WIDE_MASK   = 16'hFFFF;
  localparam logic [15:0] NARROW_MASK = 16'h00FF;
  localparam logic [15:0] WIDE_TOP    = 16'h8000;
  localparam logic [15:0] NARROW_TOP  = 16'h0080;
  localparam logic [7:0]  COUNT_MASK_286 = 8'h1F;

  typedef struct packed {
    logic [3:0]  kind;
    logic        wide;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        carry_in;
    logic        overflow_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic        carry_out;
    logic        overflow_out;
    logic        zero_flag;
    logic        sign_flag;
    logic        parity_flag;
    logic        szp_written;
  } out_item_t;

  // control handed to the one-bit step unit
  typedef struct packed {
    kind_t kind;
    logic  wide;
  } step_ctl_t;

  // zero/sign/parity status
  typedef struct packed {
    logic zf;
    logic sf;
    logic pf;
  } szp_t;

  function automatic logic [15:0] width_mask(input logic wide);
    width_mask = wide ? WIDE_MASK : NARROW_MASK;
  endfunction

  function automatic logic [15:0] top_mask(input logic wide);
    top_mask = wide ? WIDE_TOP : NARROW_TOP;
  endfunction

endpackage

// File: src/xsr_step.sv
module xsr_step
  import xsr_pkg::*;
(
  input  step_ctl_t   ctl,
  input  logic [15:0] res_i,
  input  logic        cf_i,
  output logic [15:0] res_o,
  output logic        cf_o
);

  logic [15:0] msk;
  logic [15:0] top;
  logic        top_bit;

  always_comb begin
    msk     = width_mask(ctl.wide);
    top     = top_mask(ctl.wide);
    top_bit = |(res_i & top);
    res_o   = res_i;
    cf_o    = cf_i;
    case (ctl.kind)
      OP_SHL: begin
        cf_o  = top_bit;
        res_o = (res_i << 1) & msk;
      end
      OP_SHR: begin
        cf_o  = res_i[0];
        res_o = res_i >> 1;
      end
      OP_SAR: begin
        cf_o  = res_i[0];
        res_o = (res_i >> 1) | (res_i & top);
      end
      OP_ROL: begin
        cf_o  = top_bit;
        res_o = ((res_i << 1) & msk) | {15'd0, top_bit};
      end
      OP_ROR: begin
        cf_o  = res_i[0];
        res_o = (res_i >> 1) | (res_i[0] ? top : 16'd0);
      end
      OP_RCL: begin
        cf_o  = top_bit;
        res_o = ((res_i << 1) & msk) | {15'd0, cf_i};
      end
      OP_RCR: begin
        cf_o  = res_i[0];
        res_o = (res_i >> 1) | (cf_i ? top : 16'd0);
      end
      default: begin
        res_o = res_i;
        cf_o  = cf_i;
      end
    endcase
  end

endmodule

// File: src/xsr_flags.sv
module xsr_flags
  import xsr_pkg::*;
(
  input  logic        wide,
  input  logic [15:0] res,
  output szp_t        szp
);

  always_comb begin
    szp.zf = ((res & width_mask(wide)) == 16'd0);
    szp.sf = |(res & top_mask(wide));
    szp.pf = ~^res[7:0];
  end

endmodule

// File: src/x86_logic_shift_rotate_unit.sv
// 8086-style logic/shift/rotate slice for 8- or 16-bit operands. One item is
// in flight at a time: in_stall stays high from the accepting edge until the
// result transfer completes. Logic ops and undefined kinds finish without
// stepping; shifts and rotates take count one-bit steps, where count is the
// low byte of operand_b (0..255), or its low five bits (0..31) when
// mask_count_286 is set, since a single one-bit step unit is applied once
// per cycle. The result is captured into out_data when stepping ends and is
// held with out_valid until it is taken. mask_count_286 is written through
// cfg_wr_en/cfg_wr_data and should only change while the block is idle.
module x86_logic_shift_rotate_unit
  import xsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  // configuration
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  // input channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // one-hot sequencer: idle, stepping, result waiting
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   mask_r;

  // working registers of the item in flight
  kind_t       kind_r;
  logic        wide_r;
  logic [15:0] res_r;
  logic        cf_r;
  logic        of_r;
  logic [7:0]  cnt_r;
  logic        cnt_one_r;   // count was exactly one: overflow rule applies
  logic        szp_r;       // zero/sign/parity get written
  logic        a_top_r;     // top bit of the original operand, for shr
  out_item_t   out_r;

  // accept-side decode
  logic        in_fire;
  logic [15:0] a_m;
  logic [15:0] b_m;
  logic [15:0] logic_res;
  logic [7:0]  cnt_load;
  logic        is_logic;
  logic        is_shift;
  logic        is_shrot;

  // step unit and finish logic
  step_ctl_t   step_ctl;
  logic [15:0] step_res;
  logic        step_cf;
  szp_t        szp;
  logic        msb;
  logic        nxt_bit;
  logic        of_fin;
  logic        finish;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (state_r == ST_DONE);
  assign out_data  = out_r;
  assign finish    = (state_r == ST_RUN) && (cnt_r == 8'd0);

  always_comb begin
    a_m      = in_data.operand_a & width_mask(in_data.wide);
    b_m      = in_data.operand_b & width_mask(in_data.wide);
    cnt_load = mask_r ? (in_data.operand_b[7:0] & COUNT_MASK_286)
                      : in_data.operand_b[7:0];
    is_logic = (in_data.kind <= OP_XOR);
    is_shift = (in_data.kind >= OP_SHL) && (in_data.kind <= OP_SAR);
    is_shrot = (in_data.kind >= OP_SHL) && (in_data.kind <= OP_RCR);
    case (in_data.kind)
      OP_AND:  logic_res = a_m & b_m;
      OP_OR:   logic_res = a_m | b_m;
      OP_XOR:  logic_res = a_m ^ b_m;
      default: logic_res = a_m;
    endcase
  end

  // the shared one-bit shifter
  assign step_ctl.kind = kind_r;
  assign step_ctl.wide = wide_r;

  xsr_step u_step (
    .ctl   (step_ctl),
    .res_i (res_r),
    .cf_i  (cf_r),
    .res_o (step_res),
    .cf_o  (step_cf)
  );

  xsr_flags u_flags (
    .wide (wide_r),
    .res  (res_r),
    .szp  (szp)
  );

  // overflow for a count of one, from the final value (shr: from the original top bit)
  always_comb begin
    msb     = |(res_r & top_mask(wide_r));
    nxt_bit = |(res_r & (top_mask(wide_r) >> 1));
    of_fin  = of_r;
    if (cnt_one_r) begin
      case (kind_r) inside
        OP_SHL, OP_ROL, OP_RCL: of_fin = msb ^ cf_r;
        OP_SHR:                 of_fin = a_top_r;
        OP_SAR:                 of_fin = 1'b0;
        OP_ROR, OP_RCR:         of_fin = msb ^ nxt_bit;
        default:                of_fin = of_r;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_RUN;
      ST_RUN:  if (cnt_r == 8'd0) state_nxt = ST_DONE;
      ST_DONE: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mask_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) mask_r <= cfg_wr_data;
    end
  end

  // datapath: load on accept, one step per cycle, capture on finish
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= kind_t'(in_data.kind);
      wide_r    <= in_data.wide;
      res_r     <= is_logic ? logic_res : a_m;
      cf_r      <= is_logic ? 1'b0 : in_data.carry_in;
      of_r      <= is_logic ? 1'b0 : in_data.overflow_in;
      cnt_r     <= is_shrot ? cnt_load : 8'd0;
      cnt_one_r <= is_shrot && (cnt_load == 8'd1);
      szp_r     <= is_logic || (is_shift && (cnt_load != 8'd0));
      a_top_r   <= |(a_m & top_mask(in_data.wide));
    end else if ((state_r == ST_RUN) && (cnt_r != 8'd0)) begin
      res_r <= step_res;
      cf_r  <= step_cf;
      cnt_r <= cnt_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r.result       <= res_r & width_mask(wide_r);
      out_r.carry_out    <= cf_r;
      out_r.overflow_out <= of_fin;
      out_r.zero_flag    <= szp_r && szp.zf;
      out_r.sign_flag    <= szp_r && szp.sf;
      out_r.parity_flag  <= szp_r && szp.pf;
      out_r.szp_written  <= szp_r;
    end
  end

endmodule

// File: dv/x86_logic_shift_rotate_unit_tb.sv
`timescale 1ns / 1ps

module x86_logic_shift_rotate_unit_tb;
  import xsr_pkg::*;

  // kind codes past the last defined operation; the block passes operand_a through
  localparam logic [3:0] KIND_UNDEF_LO = 4'd10;
  localparam logic [3:0] KIND_UNDEF_HI = 4'd15;
  // slowest item steps through a shift count of 255 plus overhead, so this limit is several times over
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  // expected-result tracker: predicts each accepted operation and checks results in order
  class shift_alu_scoreboard;
    out_item_t pending_results[$];
    bit        count_mask_286;
    int        failures;
    int        compared;

    function new();
      count_mask_286 = 1'b0;
      failures       = 0;
      compared       = 0;
    endfunction

    function out_item_t predict_alu_result(in_item_t op);
      logic [15:0] msk, top, a, s, res;
      logic [7:0]  count;
      logic        cf, of, szp, spill, msb, nxt;
      int          step;
      out_item_t   r;
      msk = op.wide ? WIDE_MASK : NARROW_MASK;
      top = op.wide ? WIDE_TOP : NARROW_TOP;
      a   = op.operand_a & msk;
      res = a;
      cf  = op.carry_in;
      of  = op.overflow_in;
      szp = 1'b0;
      case (op.kind)
        OP_AND, OP_OR, OP_XOR: begin
          s = op.operand_b & msk;
          if (op.kind == OP_AND) res = a & s;
          else if (op.kind == OP_OR) res = a | s;
          else res = a ^ s;
          cf  = 1'b0;
          of  = 1'b0;
          szp = 1'b1;
        end
        OP_SHL, OP_SHR, OP_SAR, OP_ROL, OP_ROR, OP_RCL, OP_RCR: begin
          count = op.operand_b[7:0];
          if (count_mask_286) count = count & COUNT_MASK_286;
          // one bit per step, counts past the width keep going
          for (step = 0; step < count; step++) begin
            case (op.kind)
              OP_SHL: begin
                cf  = |(res & top);
                res = (res << 1) & msk;
              end
              OP_SHR: begin
                cf  = res[0];
                res = res >> 1;
              end
              OP_SAR: begin
                cf  = res[0];
                res = (res >> 1) | (res & top);
              end
              OP_ROL: begin
                cf  = |(res & top);
                res = ((res << 1) & msk) | {15'd0, cf};
              end
              OP_ROR: begin
                cf  = res[0];
                res = (res >> 1) | (cf ? top : 16'd0);
              end
              OP_RCL: begin
                spill = |(res & top);
                res   = ((res << 1) & msk) | {15'd0, cf};
                cf    = spill;
              end
              default: begin
                spill = res[0];
                res   = (res >> 1) | (cf ? top : 16'd0);
                cf    = spill;
              end
            endcase
          end
          // overflow only moves for a single-bit count
          if (count == 8'd1) begin
            msb = |(res & top);
            nxt = |(res & (top >> 1));
            case (op.kind)
              OP_SHL, OP_ROL, OP_RCL: of = msb ^ cf;
              OP_SHR: of = |(a & top);
              OP_SAR: of = 1'b0;
              default: of = msb ^ nxt;
            endcase
          end
          if ((op.kind == OP_SHL || op.kind == OP_SHR || op.kind == OP_SAR) && count != 8'd0)
            szp = 1'b1;
        end
        default: ;
      endcase
      r = '0;
      r.result       = res & msk;
      r.carry_out    = cf;
      r.overflow_out = of;
      r.szp_written  = szp;
      if (szp) begin
        r.zero_flag   = (r.result == 16'd0);
        r.sign_flag   = |(r.result & top);
        r.parity_flag = ~^r.result[7:0];
      end
      return r;
    endfunction

    function void note_operation(in_item_t op);
      pending_results.push_back(predict_alu_result(op));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result transfer with nothing expected: result=%h cf=%b of=%b szp=%b",
                   got.result, got.carry_out, got.overflow_out, got.szp_written);
        return;
      end
      want = pending_results.pop_front();
      compared++;
      if (got.result !== want.result || got.carry_out !== want.carry_out ||
          got.overflow_out !== want.overflow_out || got.zero_flag !== want.zero_flag ||
          got.sign_flag !== want.sign_flag || got.parity_flag !== want.parity_flag ||
          got.szp_written !== want.szp_written) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("mismatch at %0t: exp res=%h cf=%b of=%b z=%b s=%b p=%b w=%b / got res=%h cf=%b of=%b z=%b s=%b p=%b w=%b",
                   $realtime, want.result, want.carry_out, want.overflow_out, want.zero_flag,
                   want.sign_flag, want.parity_flag, want.szp_written, got.result,
                   got.carry_out, got.overflow_out, got.zero_flag, got.sign_flag,
                   got.parity_flag, got.szp_written);
      end
    endfunction
  endclass

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_item_t out_data;

  shift_alu_scoreboard alu_checker;
  bit no_gaps     = 1'b0;   // when set both sides run back to back
  int ops_sent    = 0;
  int masked_ops  = 0;
  int idle_cycles = 0;

  x86_logic_shift_rotate_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic in_item_t make_op(logic [3:0] kind, logic wide, logic [15:0] a,
                                       logic [15:0] b, logic cf, logic of);
    in_item_t op;
    op.kind        = kind;
    op.wide        = wide;
    op.operand_a   = a;
    op.operand_b   = b;
    op.carry_in    = cf;
    op.overflow_in = of;
    return op;
  endfunction

  // shift counts: mostly around the operand widths, a few up to the full byte
  function automatic logic [7:0] draw_shift_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 8'd0;
    else if (pick < 20) return 8'd1;
    else if (pick < 70) return 8'($urandom_range(2, 17));
    else if (pick < 85) return 8'($urandom_range(18, 31));
    else return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t random_operation();
    in_item_t op;
    int       pick;
    if ($urandom_range(0, 19) == 0)
      op.kind = 4'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
    else
      op.kind = 4'($urandom_range(OP_AND, OP_RCR));
    op.wide = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    // bias toward all-zero, all-one, sign-bit and low-bit patterns
    case (pick)
      0: op.operand_a = 16'h0000;
      1: op.operand_a = 16'hFFFF;
      2: op.operand_a = 16'h8080;
      3: op.operand_a = 16'h0001;
      default: op.operand_a = 16'($urandom);
    endcase
    if (op.kind <= OP_XOR)
      op.operand_b = 16'($urandom);
    else
      op.operand_b = {8'($urandom), draw_shift_count()};
    op.carry_in    = 1'($urandom_range(0, 1));
    op.overflow_in = 1'($urandom_range(0, 1));
    return op;
  endfunction

  // present one operation after a random gap (none when no_gaps is set) and hold it until the transfer
  task automatic send_operation(input in_item_t op);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall !== 1'b0);
    alu_checker.note_operation(op);
    ops_sent++;
    if (alu_checker.count_mask_286) masked_ops++;
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (alu_checker.pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_count_mode(input logic mask_on);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask_on;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    alu_checker.count_mask_286 = mask_on;
  endtask

  task automatic run_random(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      // every so often switch between gapped traffic and a back-to-back burst
      if (k % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_operation(random_operation());
    end
  endtask

  // result side: stall a random number of valid cycles (none when no_gaps is set), then take the transfer
  initial begin
    int hold;
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        while (hold > 0) begin
          @(posedge clk);
          if (out_valid === 1'b1) hold--;
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // compare every result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      alu_checker.check_result(out_data);
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("x86_logic_shift_rotate_unit verification failed");
      $finish;
    end
  end

  initial begin
    alu_checker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_count_mode(1'b0);

    // directed: each operation, single-bit counts, zero counts, long counts
    send_operation(make_op(OP_AND, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_operation(make_op(OP_OR,  1'b0, 16'hFF00, 16'hFF00, 1'b1, 1'b0));
    send_operation(make_op(OP_XOR, 1'b1, 16'h8000, 16'h0001, 1'b0, 1'b1));
    send_operation(make_op(OP_SHL, 1'b0, 16'h0080, 16'h0001, 1'b0, 1'b0));
    send_operation(make_op(OP_SHR, 1'b1, 16'h8001, 16'h0001, 1'b0, 1'b0));
    send_operation(make_op(OP_SAR, 1'b0, 16'h0081, 16'h0001, 1'b0, 1'b1));
    send_operation(make_op(OP_ROL, 1'b1, 16'h8000, 16'h0001, 1'b0, 1'b0));
    send_operation(make_op(OP_ROR, 1'b0, 16'h0001, 16'h0001, 1'b0, 1'b0));
    send_operation(make_op(OP_RCL, 1'b1, 16'h8000, 16'h0001, 1'b0, 1'b0));
    send_operation(make_op(OP_RCR, 1'b0, 16'h0001, 16'h0001, 1'b1, 1'b0));
    // zero count keeps the incoming flags and writes no status
    send_operation(make_op(OP_SHL, 1'b1, 16'h1234, 16'hFF00, 1'b1, 1'b1));
    send_operation(make_op(OP_RCR, 1'b1, 16'hABCD, 16'h0000, 1'b1, 1'b1));
    // counts at and past the operand width
    send_operation(make_op(OP_SHL, 1'b0, 16'hFFFF, 16'h0009, 1'b0, 1'b1));
    send_operation(make_op(OP_SAR, 1'b1, 16'h8000, 16'h0011, 1'b0, 1'b0));
    send_operation(make_op(OP_RCL, 1'b0, 16'h005A, 16'h0009, 1'b1, 1'b0));
    send_operation(make_op(OP_RCR, 1'b1, 16'hC3A5, 16'h0011, 1'b1, 1'b1));
    send_operation(make_op(OP_ROL, 1'b0, 16'h00B7, 16'hFFFF, 1'b0, 1'b1));
    send_operation(make_op(OP_SHR, 1'b1, 16'hFFFF, 16'h0120, 1'b1, 1'b0));
    send_operation(make_op(OP_ROR, 1'b1, 16'h0001, 16'h001F, 1'b0, 1'b0));
    send_operation(make_op(OP_SHL, 1'b1, 16'hFFFF, 16'h0010, 1'b0, 1'b0));
    // undefined kinds pass the operand through
    send_operation(make_op(KIND_UNDEF_LO, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
    send_operation(make_op(KIND_UNDEF_HI, 1'b0, 16'hA5C3, 16'h0001, 1'b0, 1'b1));

    run_random(500);
    drain_results();
    write_count_mode(1'b1);
    run_random(500);
    drain_results();
    write_count_mode(1'b0);
    run_random(280);
    drain_results();
    write_count_mode(1'b1);
    run_random(250);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d operations (%0d with 286 count masking), compared %0d results, %0d mismatches",
             ops_sent, masked_ops, alu_checker.compared, alu_checker.failures);
    if (alu_checker.pending_results.size() != 0)
      $display("%0d expected results never arrived", alu_checker.pending_results.size());
    if (alu_checker.failures == 0 && alu_checker.pending_results.size() == 0) begin
      $display("x86_logic_shift_rotate_unit verification clean");
    end else begin
      $display("x86_logic_shift_rotate_unit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/xsr_pkg.sv
src/xsr_step.sv
src/xsr_flags.sv
src/x86_logic_shift_rotate_unit.sv
dv/x86_logic_shift_rotate_unit_tb.sv
